[hw/rtl/mie_pkg.sv]
// Shared constants for the modular inverse block.
// Used by modular_inverse_ext_euclid and its testbench; no dependencies.
`timescale 1ns / 1ps

package mie_pkg;

    // Width of the value, modulus and inverse ports
    localparam int FIELD_BITS = 64;

    // Default internal word width (low bits of each input that are used)
    localparam int WORD_BITS_DEF = 64;

endpackage : mie_pkg

[hw/rtl/modular_inverse_ext_euclid.sv]
// Modular inverse by extended Euclid: sequencer, working registers, output register.
// Depends on mie_pkg and mie_alu.
//
//  channel  handshake          payload
//  -------  -----------------  ---------------------------------
//  input    in_valid/in_stall  value[63:0], modulus[63:0]
//  output   out_valid/out_stall inverse[63:0], invertible
//
// Each division is shift-subtract: the divisor is doubled one bit per cycle,
// then one quotient bit per cycle is taken through the shared compare/subtract.
// An invertible result takes the accept, the reduction (align, quotient bits),
// each Euclid step (check, align, quotient bits), two fix-up steps and the output
// load. Worst case is consecutive Fibonacci operands; small operands finish far sooner.
// in_stall is high from the input transfer until the result moves into the
// output register; the output register holds while out_stall is high.
// rst_n clears the sequencer and the output valid.
`timescale 1ns / 1ps

module modular_inverse_ext_euclid #(
    parameter int WORD_BITS = mie_pkg::WORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [mie_pkg::FIELD_BITS-1:0]  value,
    input  logic [mie_pkg::FIELD_BITS-1:0]  modulus,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [mie_pkg::FIELD_BITS-1:0]  inverse,
    output logic                            invertible
);

    localparam int W  = WORD_BITS;
    localparam int KW = $clog2(WORD_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_DN,
        S_CHK,
        S_FIX1,
        S_FIX2,
        S_DONE
    } state_t;

    state_t         state_reg, state_next;
    logic [W-1:0]   mod_reg, mod_next;
    logic [W-1:0]   r0_reg, r0_next;
    logic [W-1:0]   r1_reg, r1_next;
    logic [W-1:0]   d_reg, d_next;
    logic [W-1:0]   u0_reg, u0_next;
    logic [W-1:0]   u1_reg, u1_next;
    logic [W-1:0]   e_reg, e_next;
    logic [W-1:0]   acc_reg, acc_next;
    logic [KW-1:0]  k_reg, k_next;
    logic           n0_reg, n0_next;
    logic           n1_reg, n1_next;
    logic           eu_reg, eu_next;
    logic           ok_reg, ok_next;
    logic           out_valid_reg, out_valid_next;
    logic [W-1:0]   out_inv_reg, out_inv_next;
    logic           out_ok_reg, out_ok_next;

    logic [W-1:0]   alu_x, alu_y;
    logic           alu_ge;
    logic [W-1:0]   alu_diff, alu_sum;
    logic [W-1:0]   a_in, m_in;
    logic [W-1:0]   r0_w, acc_w;

    assign a_in = value[W-1:0];
    assign m_in = modulus[W-1:0];

    // Operand selection for the shared unit
    always_comb
    begin
        unique case (state_reg)
            S_UP:
            begin
                alu_x = r0_reg >> 1;
                alu_y = d_reg;
            end
            S_FIX1:
            begin
                alu_x = u0_reg;
                alu_y = mod_reg;
            end
            S_FIX2:
            begin
                alu_x = mod_reg;
                alu_y = u0_reg;
            end
            default:
            begin
                alu_x = r0_reg;
                alu_y = d_reg;
            end
        endcase
    end

    mie_alu #(
        .WORD_BITS(WORD_BITS)
    ) u_alu (
        .x    (alu_x),
        .y    (alu_y),
        .ax   (acc_reg),
        .ay   (e_reg),
        .ge   (alu_ge),
        .diff (alu_diff),
        .sum  (alu_sum)
    );

    // Quotient bit taken or not
    assign r0_w  = alu_ge ? alu_diff : r0_reg;
    assign acc_w = alu_ge ? alu_sum : acc_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        mod_next       = mod_reg;
        r0_next        = r0_reg;
        r1_next        = r1_reg;
        d_next         = d_reg;
        u0_next        = u0_reg;
        u1_next        = u1_reg;
        e_next         = e_reg;
        acc_next       = acc_reg;
        k_next         = k_reg;
        n0_next        = n0_reg;
        n1_next        = n1_reg;
        eu_next        = eu_reg;
        ok_next        = ok_reg;
        out_inv_next   = out_inv_reg;
        out_ok_next    = out_ok_reg;
        out_valid_next = out_stall ? out_valid_reg : 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mod_next = m_in;
                    if (m_in == '0)
                    begin
                        u0_next    = '0;
                        ok_next    = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // reduce value mod modulus first
                        r0_next    = a_in;
                        r1_next    = m_in;
                        d_next     = m_in;
                        e_next     = '0;
                        acc_next   = '0;
                        k_next     = '0;
                        eu_next    = 1'b0;
                        state_next = S_UP;
                    end
                end
            end

            // align divisor under the dividend
            S_UP:
            begin
                if (alu_ge)
                begin
                    d_next = d_reg << 1;
                    e_next = e_reg << 1;
                    k_next = k_reg + 1'b1;
                end
                else
                begin
                    state_next = S_DN;
                end
            end

            // one quotient bit per cycle
            S_DN:
            begin
                r0_next  = r0_w;
                acc_next = acc_w;
                if (k_reg == '0)
                begin
                    if (!eu_reg)
                    begin
                        if (r0_w == '0)
                        begin
                            u0_next    = '0;
                            ok_next    = 1'b0;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            r0_next    = mod_reg;
                            r1_next    = r0_w;
                            u0_next    = '0;
                            u1_next    = W'(1);
                            n0_next    = 1'b0;
                            n1_next    = 1'b0;
                            eu_next    = 1'b1;
                            state_next = S_CHK;
                        end
                    end
                    else
                    begin
                        // rotate remainders and coefficients
                        r0_next    = r1_reg;
                        r1_next    = r0_w;
                        u0_next    = u1_reg;
                        u1_next    = acc_w;
                        n0_next    = n1_reg;
                        n1_next    = !n1_reg;
                        state_next = S_CHK;
                    end
                end
                else
                begin
                    d_next = d_reg >> 1;
                    e_next = e_reg >> 1;
                    k_next = k_reg - 1'b1;
                end
            end

            S_CHK:
            begin
                if (r1_reg == '0)
                begin
                    if (r0_reg == W'(1))
                    begin
                        state_next = S_FIX1;
                    end
                    else
                    begin
                        u0_next    = '0;
                        ok_next    = 1'b0;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    d_next     = r1_reg;
                    e_next     = u1_reg;
                    acc_next   = u0_reg;
                    k_next     = '0;
                    state_next = S_UP;
                end
            end

            // bring coefficient below the modulus
            S_FIX1:
            begin
                if (alu_ge)
                begin
                    u0_next = alu_diff;
                end
                state_next = S_FIX2;
            end

            // negative coefficient maps to modulus minus magnitude
            S_FIX2:
            begin
                if (n0_reg && (u0_reg != '0))
                begin
                    u0_next = alu_diff;
                end
                ok_next    = 1'b1;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_inv_next   = u0_reg;
                    out_ok_next    = ok_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mod_reg       <= '0;
            r0_reg        <= '0;
            r1_reg        <= '0;
            d_reg         <= '0;
            u0_reg        <= '0;
            u1_reg        <= '0;
            e_reg         <= '0;
            acc_reg       <= '0;
            k_reg         <= '0;
            n0_reg        <= 1'b0;
            n1_reg        <= 1'b0;
            eu_reg        <= 1'b0;
            ok_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            out_inv_reg   <= '0;
            out_ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mod_reg       <= mod_next;
            r0_reg        <= r0_next;
            r1_reg        <= r1_next;
            d_reg         <= d_next;
            u0_reg        <= u0_next;
            u1_reg        <= u1_next;
            e_reg         <= e_next;
            acc_reg       <= acc_next;
            k_reg         <= k_next;
            n0_reg        <= n0_next;
            n1_reg        <= n1_next;
            eu_reg        <= eu_next;
            ok_reg        <= ok_next;
            out_valid_reg <= out_valid_next;
            out_inv_reg   <= out_inv_next;
            out_ok_reg    <= out_ok_next;
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign inverse    = mie_pkg::FIELD_BITS'(out_inv_reg);
    assign invertible = out_ok_reg;

`ifndef SYNTHESIS
    // an input transfer always starts work
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != S_IDLE))
        else $error("input transfer did not start a computation");

    // divisor never zero while dividing
    a_div_nz: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_UP) || (state_reg == S_DN)) |-> (d_reg != '0))
        else $error("zero divisor in shift-subtract");

    // shifted coefficient stays within the modulus
    a_coef: assert property (@(posedge clk) disable iff (!rst_n)
        (eu_reg && ((state_reg == S_UP) || (state_reg == S_DN))) |-> (e_reg <= mod_reg))
        else $error("coefficient magnitude exceeds modulus");

    // non-invertible results are zero
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ok_reg) |-> (out_inv_reg == '0))
        else $error("nonzero inverse without invertible flag");

    // invertible result is reduced
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && ok_reg) |-> (u0_reg < mod_reg))
        else $error("inverse not below modulus");
`endif

endmodule : modular_inverse_ext_euclid

[hw/rtl/mie_alu.sv]
// Shared arithmetic unit: one wide compare/subtract and one wide add.
// Depends on nothing; instantiated by modular_inverse_ext_euclid.
`timescale 1ns / 1ps

module mie_alu #(
    parameter int WORD_BITS = 64
) (
    input  logic [WORD_BITS-1:0] x,
    input  logic [WORD_BITS-1:0] y,
    input  logic [WORD_BITS-1:0] ax,
    input  logic [WORD_BITS-1:0] ay,
    output logic                 ge,
    output logic [WORD_BITS-1:0] diff,
    output logic [WORD_BITS-1:0] sum
);

    // Compare and subtract share the same operands
    assign ge   = (x >= y);
    assign diff = x - y;

    // Coefficient accumulation; magnitudes stay below the modulus
    assign sum  = ax + ay;

endmodule : mie_alu

[bench/modular_inverse_ext_euclid_tb.sv]
// Self-checking bench for modular_inverse_ext_euclid: a directed table of edge cases,
// then random pairs, scored against by_hand values or a local extended-Euclid model.
// Depends on mie_pkg and the modular_inverse_ext_euclid RTL.
`timescale 1ns / 1ps

module modular_inverse_ext_euclid_tb;

    typedef logic [mie_pkg::FIELD_BITS-1:0] word_t;

    typedef struct packed {
        word_t inv;
        logic  ok;
    } inv_result_t;

    // One directed row; by_hand rows carry their own expected result
    typedef struct packed {
        word_t value;
        word_t modulus;
        logic  by_hand;
        word_t exp_inv;
        logic  exp_ok;
    } dir_row_t;

    localparam int          FIELD_BITS     = mie_pkg::FIELD_BITS;
    localparam int          WORD_BITS      = mie_pkg::WORD_BITS_DEF;
    localparam int          RESET_CYCLES   = 7;
    localparam int          N_DIRECTED     = 24;
    localparam int          N_RANDOM       = 1000;
    localparam int          LONG_HOLD      = 1500;
    localparam int          LONG_HOLD_AT   = 250;
    localparam int          DRAIN_CYCLES   = 1000;
    localparam int          WATCHDOG_LIMIT = 12000;
    localparam int          MAX_PRINTED    = 40;
    localparam logic        HAND           = 1'b1;
    localparam logic        PRED           = 1'b0;
    localparam word_t       ALL_ONES       = '1;
    localparam word_t       TOP_BIT        = 64'h8000_0000_0000_0000;
    localparam word_t       PRIME_64       = 64'hFFFF_FFFF_FFFF_FFC5;
    localparam word_t       FIB_92         = 64'd7540113804746346429;
    localparam word_t       FIB_93         = 64'd12200160415121876738;

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_stall;
    word_t value;
    word_t modulus;
    logic  out_valid;
    logic  out_stall;
    word_t inverse;
    logic  invertible;

    inv_result_t inverse_q[$];
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned invertible_seen;
    int unsigned mismatches;
    int unsigned idle_cycles;

    // Edge cases: zero modulus, modulus one, value reducing to zero, shared factors,
    // moduli at the top of the range, and the Fibonacci pair with the most Euclid steps
    dir_row_t directed_rows [N_DIRECTED] = '{
        '{64'd5,            64'd0,       HAND, 64'd0,            1'b0},
        '{64'd0,            64'd0,       HAND, 64'd0,            1'b0},
        '{ALL_ONES,         64'd0,       HAND, 64'd0,            1'b0},
        '{64'd7,            64'd1,       HAND, 64'd0,            1'b0},
        '{64'd0,            64'd13,      HAND, 64'd0,            1'b0},
        '{64'd26,           64'd13,      HAND, 64'd0,            1'b0},
        '{64'd6,            64'd9,       HAND, 64'd0,            1'b0},
        '{ALL_ONES,         ALL_ONES,    HAND, 64'd0,            1'b0},
        '{64'd1,            64'd13,      HAND, 64'd1,            1'b1},
        '{64'd3,            64'd7,       HAND, 64'd5,            1'b1},
        '{64'd12,           64'd13,      HAND, 64'd12,           1'b1},
        '{64'd1,            64'd2,       HAND, 64'd1,            1'b1},
        '{ALL_ONES,         64'd2,       HAND, 64'd1,            1'b1},
        '{64'd2,            ALL_ONES,    HAND, TOP_BIT,          1'b1},
        '{ALL_ONES - 64'd1, ALL_ONES,    HAND, ALL_ONES - 64'd1, 1'b1},
        '{64'd3,            ALL_ONES,    HAND, 64'd0,            1'b0},
        '{64'd1,            ALL_ONES,    HAND, 64'd1,            1'b1},
        '{TOP_BIT,          ALL_ONES,    HAND, 64'd2,            1'b1},
        '{PRIME_64 - 64'd1, PRIME_64,    HAND, PRIME_64 - 64'd1, 1'b1},
        '{FIB_92,           FIB_93,      PRED, 64'd0,            1'b0},
        '{FIB_93,           FIB_92,      PRED, 64'd0,            1'b0},
        '{64'h0123_4567_89AB_CDEF, PRIME_64, PRED, 64'd0,        1'b0},
        '{ALL_ONES,         TOP_BIT + 64'd1, PRED, 64'd0,        1'b0},
        '{64'd10,           64'd17,      PRED, 64'd0,            1'b0}
    };

    modular_inverse_ext_euclid dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .modulus    (modulus),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .inverse    (inverse),
        .invertible (invertible)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Extended Euclid on (modulus, value mod modulus), coefficient as magnitude + sign
    function automatic inv_result_t compute_inverse(word_t v, word_t m);
        word_t       msk;
        word_t       a;
        word_t       md;
        word_t       r_prev;
        word_t       r_cur;
        word_t       quo;
        word_t       rem;
        word_t       c_prev;
        word_t       c_cur;
        word_t       c_next;
        logic        neg_prev;
        logic        neg_cur;
        inv_result_t res;
        msk = ALL_ONES >> (FIELD_BITS - WORD_BITS);
        a   = v & msk;
        md  = m & msk;
        res = '0;
        if (md != '0)
        begin
            a = a % md;
            if (a != '0)
            begin
                r_prev   = md;
                r_cur    = a;
                c_prev   = '0;
                neg_prev = 1'b0;
                c_cur    = 64'd1;
                neg_cur  = 1'b0;
                while (r_cur != '0)
                begin
                    quo      = r_prev / r_cur;
                    rem      = r_prev - quo * r_cur;
                    r_prev   = r_cur;
                    r_cur    = rem;
                    // signs alternate, so magnitudes add
                    c_next   = c_prev + quo * c_cur;
                    c_prev   = c_cur;
                    neg_prev = neg_cur;
                    c_cur    = c_next;
                    neg_cur  = !neg_prev;
                end
                if (r_prev == 64'd1)
                begin
                    if (c_prev >= md)
                        c_prev = c_prev % md;
                    res.inv = (neg_prev && c_prev != '0) ? md - c_prev : c_prev;
                    res.ok  = 1'b1;
                end
            end
        end
        return res;
    endfunction

    // Random word with only the low 'bits' bits live
    function automatic word_t rand_word(int unsigned bits);
        word_t w;
        w = {$urandom, $urandom};
        return (bits == 0) ? '0 : w >> (FIELD_BITS - bits);
    endfunction

    // Operand width: mostly small, a few at full size
    function automatic int unsigned pick_width();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return $urandom_range(1, 12);
        else if (r < 88)
            return $urandom_range(13, 40);
        return $urandom_range(41, FIELD_BITS);
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(50, 200);
    endfunction

    task automatic report_mismatch(string what, word_t got, word_t want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("%0t: result %0d %s: got %h, expected %h",
                     $time, results_seen, what, got, want);
    endtask

    // Offer one item and hold it until the transfer; log its expected result then
    task automatic send_item(word_t v, word_t m, inv_result_t want);
        value    <= v;
        modulus  <= m;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        inverse_q.push_back(want);
        items_sent++;
    endtask

    // Drop valid for the given idle length, with junk on the payload
    task automatic idle_sender(int unsigned n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            value    <= {$urandom, $urandom};
            modulus  <= {$urandom, $urandom};
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (inverse_q.size() != 0)
            @(posedge clk);
    endtask

    // Sender: reset, directed table, then random operand pairs
    initial
    begin
        inv_result_t want;
        word_t       v;
        word_t       m;
        word_t       g;
        int unsigned r;
        int unsigned gap;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        value    <= '0;
        modulus  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (directed_rows[i].by_hand)
                want = '{inv: directed_rows[i].exp_inv, ok: directed_rows[i].exp_ok};
            else
                want = compute_inverse(directed_rows[i].value, directed_rows[i].modulus);
            send_item(directed_rows[i].value, directed_rows[i].modulus, want);
            idle_sender(pick_gap());
        end
        wait_drained();

        for (int i = 0; i < N_RANDOM; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
            begin
                v = rand_word(FIELD_BITS);
                m = '0;
            end
            else if (r < 7)
            begin
                v = rand_word(pick_width());
                m = 64'd1;
            end
            else if (r < 12)
            begin
                // multiple of the modulus
                m = rand_word(pick_width() / 2 + 1);
                v = m * rand_word($urandom_range(1, 16));
            end
            else if (r < 22)
            begin
                // shared factor above one
                g = $urandom_range(2, 50);
                v = g * rand_word(pick_width() / 2 + 1);
                m = g * rand_word(pick_width() / 2 + 1);
            end
            else if (r < 30)
            begin
                v = rand_word(FIELD_BITS);
                m = rand_word(FIELD_BITS);
            end
            else
            begin
                v = rand_word(pick_width());
                m = rand_word(pick_width());
            end
            send_item(v, m, compute_inverse(v, m));

            // back-to-back window, one full drain midway, random gaps elsewhere
            if (i == N_RANDOM / 2)
                wait_drained();
            else
            begin
                gap = (i >= 300 && i < 400) ? 0 : pick_gap();
                idle_sender(gap);
            end
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d items (%0d directed, %0d random); checked %0d results,",
                 items_sent, N_DIRECTED, N_RANDOM, results_seen);
        $display("%0d invertible, %0d without inverse; %0d mismatches.",
                 invertible_seen, results_seen - invertible_seen, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: random stalls, one long hold-off, a window with no stalls
    initial
    begin
        int unsigned hold;
        bit          long_done;
        long_done = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!long_done && results_seen >= LONG_HOLD_AT)
            begin
                long_done = 1'b1;
                hold      = LONG_HOLD;
            end
            else if (results_seen >= 700 && results_seen < 800)
                hold = 0;
            else
                hold = pick_gap();
            if (hold == 0)
                out_stall <= 1'b0;
            else
            begin
                out_stall <= 1'b1;
                repeat (hold - 1) @(posedge clk);
            end
        end
    end

    // Check each output transfer against the oldest expected result
    always @(posedge clk)
    begin
        inv_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (invertible)
                invertible_seen++;
            if (inverse_q.size() == 0)
                report_mismatch("arrived with nothing pending", inverse, '0);
            else
            begin
                want = inverse_q.pop_front();
                if (inverse !== want.inv)
                    report_mismatch("inverse", inverse, want.inv);
                if (invertible !== want.ok)
                    report_mismatch("invertible", word_t'(invertible), word_t'(want.ok));
            end
        end
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles, %0d results pending",
                     idle_cycles, inverse_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
